// File: src/sapt_pkg.sv
// Shared types, codes and arithmetic helpers of the beacon advert parser.
package sapt_pkg;

  localparam int SWEEP_MAX = 8;
  localparam int JOB_BYTES = 18;   // payload bytes 4..21 travel with a frame job

  // Input command codes
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_UPLOAD = 2'd1;
  localparam logic [1:0] CMD_LOG    = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_STORED = 3'd0;
  localparam logic [2:0] KIND_DUP    = 3'd1;
  localparam logic [2:0] KIND_FULL   = 3'd2;
  localparam logic [2:0] KIND_MINMAX = 3'd3;
  localparam logic [2:0] KIND_BADLEN = 3'd4;
  localparam logic [2:0] KIND_ENTRY  = 3'd5;
  localparam logic [2:0] KIND_DONE   = 3'd6;

  typedef enum logic [2:0] {
    OP_FRAME20 = 3'd0,
    OP_FRAME22 = 3'd1,
    OP_BADLEN  = 3'd2,
    OP_UPLOAD  = 3'd3,
    OP_LOG     = 3'd4
  } sapt_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [31:0] now_ms;
  } sapt_in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         slot;
    logic [47:0]        mac_address;
    logic [6:0]         battery_percent;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic [31:0]        up_time;
    logic signed [15:0] high_temperature;
    logic [31:0]        high_time;
    logic signed [15:0] low_temperature;
    logic [31:0]        low_time;
    logic               last_result;
  } sapt_out_t;

  // Classified request handed from front to back
  typedef struct packed {
    sapt_op_t                     op;
    logic [31:0]                  now;
    logic [JOB_BYTES-1:0][7:0]    bytes;  // bytes[k] is payload byte k+4
  } sapt_job_t;

  // One slot of the sensor table
  typedef struct packed {
    logic [47:0] mac;
    logic [6:0]  battery;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [31:0] up_time;
    logic [31:0] update_time;
  } sapt_entry_t;

  // Piecewise millivolt to percent map; /10 by reciprocal 205/2048, /5 by 205/1024
  function automatic logic [6:0] battery_map(input logic [15:0] raw);
    logic [9:0]  d;
    logic [19:0] p;
    logic [6:0]  r;
    d = '0;
    p = '0;
    r = '0;
    if (raw >= 16'd3000) begin
      r = 7'd100;
    end else if (raw >= 16'd2600) begin
      d = 10'(raw - 16'd2600);
      p = 20'(d) * 20'd205;
      r = 7'd60 + 7'(p[19:11]);
    end else if (raw >= 16'd2500) begin
      d = 10'(raw - 16'd2500);
      p = 20'(d) * 20'd205;
      r = 7'd40 + 7'(p[19:10]);
    end else if (raw >= 16'd2400) begin
      d = 10'(raw - 16'd2400);
      p = 20'(d) * 20'd205;
      r = 7'd20 + 7'(p[19:10]);
    end
    return r;
  endfunction

  // raw * 10 / 16, truncated toward zero
  function automatic logic [15:0] scale_signed(input logic [15:0] raw);
    logic signed [19:0] p;
    logic signed [19:0] q;
    p = $signed({{4{raw[15]}}, raw}) * 20'sd10;
    if (p < 0) begin
      q = (p + 20'sd15) >>> 4;
    end else begin
      q = p >>> 4;
    end
    return q[15:0];
  endfunction

  function automatic logic [15:0] scale_unsigned(input logic [15:0] raw);
    logic [19:0] p;
    p = {4'b0, raw} * 20'd10;
    return p[19:4];
  endfunction

endpackage

// File: src/sapt_fifo.sv
// Small register queue, used between front and back and on the result side.
module sapt_fifo #(
  parameter type ITEM_T = logic [0:0],
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  ITEM_T din,
  input  logic  pop,
  output logic  empty,
  output ITEM_T dout
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ITEM_T            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// File: src/sapt_ram.sv
// Generic single write port RAM with registered read.
module sapt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/sapt_front.sv
// Front end: collects payload bytes and classifies finished frames and sweeps.
module sapt_front #(
  parameter int FRAME_STORE_BYTES = 22
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sapt_pkg::sapt_in_t  request,
  output logic                job_push,
  output sapt_pkg::sapt_job_t job,
  input  logic                job_full
);
  import sapt_pkg::*;

  localparam int IDX_W = $clog2(FRAME_STORE_BYTES);

  logic [7:0] frame_bytes [FRAME_STORE_BYTES];
  logic [4:0] frame_length;
  logic [4:0] length_next;
  logic       accept;
  logic       is_byte;

  assign full    = job_full;
  assign accept  = push && !job_full;
  assign is_byte = (request.command == CMD_BYTE);

  // length including this byte, saturating
  assign length_next = (frame_length == 5'd31) ? frame_length : frame_length + 5'd1;

  // frame view with the incoming byte merged in
  always_comb begin
    for (int k = 0; k < JOB_BYTES; k++) begin
      job.bytes[k] = (frame_length == 5'(k + 4)) ? request.byte_value : frame_bytes[k + 4];
    end
    job.now = request.now_ms;
    case (request.command)
      CMD_UPLOAD: job.op = OP_UPLOAD;
      CMD_LOG:    job.op = OP_LOG;
      default: begin
        if (length_next == 5'd20) begin
          job.op = OP_FRAME20;
        end else if (length_next == 5'd22) begin
          job.op = OP_FRAME22;
        end else begin
          job.op = OP_BADLEN;
        end
      end
    endcase
    job_push = accept && ((request.command == CMD_UPLOAD) || (request.command == CMD_LOG)
                          || (is_byte && request.last_byte));
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte && (frame_length < 5'(FRAME_STORE_BYTES))) begin
      frame_bytes[frame_length[IDX_W-1:0]] <= request.byte_value;
    end
    if (rst) begin
      frame_length <= '0;
    end else if (accept && is_byte) begin
      frame_length <= request.last_byte ? 5'd0 : length_next;
    end
  end
endmodule

// File: src/sapt_back.sv
// Back end: table search, store, duplicate test and sweeps over the slot table.
module sapt_back #(
  parameter int SENSOR_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  sapt_pkg::sapt_job_t job,
  input  logic                job_empty,
  output logic                job_pop,
  input  logic [31:0]         window,
  output logic                res_push,
  output sapt_pkg::sapt_out_t res,
  input  logic                res_full
);
  import sapt_pkg::*;

  localparam int SLOT_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam int CNT_W  = $clog2(SENSOR_SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_RESOLVE = 6'b000100,
    S_SW_RD   = 6'b001000,
    S_SW_EMIT = 6'b010000,
    S_SW_DONE = 6'b100000
  } state_t;

  state_t                  state;
  sapt_job_t               cur;
  logic [CNT_W-1:0]        scan_cnt;
  logic                    rd_valid;
  logic [SLOT_W-1:0]       rd_idx;
  logic                    rm_found;
  logic [SLOT_W-1:0]       rm_idx;
  logic [31:0]             rm_time;
  logic                    ch_found;
  logic [SLOT_W-1:0]       ch_idx;
  logic [SENSOR_SLOTS-1:0] upload_ready;
  logic [SENSOR_SLOTS-1:0] log_ready;
  logic [CNT_W-1:0]        sw_idx;
  logic [3:0]              sw_cnt;
  logic                    sw_log;

  sapt_entry_t       rdata;
  sapt_entry_t       wdata;
  logic              ram_we;
  logic [SLOT_W-1:0] raddr;
  logic [47:0]       cur_mac;
  logic              mac_hit;
  logic              slot_ready;
  logic              sw_flag;
  logic              is_dup20;
  logic [31:0]       dup_limit;

  sapt_ram #(
    .WIDTH ($bits(sapt_entry_t)),
    .DEPTH (SENSOR_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur_mac = {cur.bytes[0], cur.bytes[1], cur.bytes[2],
                    cur.bytes[3], cur.bytes[4], cur.bytes[5]};
  assign raddr      = (state == S_SCAN) ? scan_cnt[SLOT_W-1:0] : sw_idx[SLOT_W-1:0];
  assign mac_hit    = (rdata.mac == cur_mac);
  assign slot_ready = upload_ready[rd_idx];
  assign sw_flag    = sw_log ? log_ready[sw_idx[SLOT_W-1:0]] : upload_ready[sw_idx[SLOT_W-1:0]];
  assign dup_limit  = rm_time + window;
  assign is_dup20   = rm_found && (cur.now < dup_limit);

  // new table entry from the frame
  always_comb begin
    wdata.mac         = cur_mac;
    wdata.battery     = battery_map({cur.bytes[7], cur.bytes[6]});
    wdata.temperature = scale_signed({cur.bytes[9], cur.bytes[8]});
    wdata.humidity    = scale_unsigned({cur.bytes[11], cur.bytes[10]});
    wdata.up_time     = {cur.bytes[15], cur.bytes[14], cur.bytes[13], cur.bytes[12]};
    wdata.update_time = cur.now;
  end

  always_comb begin
    job_pop  = (state == S_IDLE) && !job_empty;
    res_push = 1'b0;
    ram_we   = 1'b0;
    res      = '0;
    case (state)
      S_RESOLVE: begin
        res_push         = !res_full;
        res.last_result  = 1'b1;
        res.mac_address  = cur_mac;
        case (cur.op)
          OP_FRAME20: begin
            if (is_dup20) begin
              res.kind = KIND_DUP;
              res.slot = 3'(rm_idx);
            end else if (ch_found) begin
              ram_we              = !res_full;
              res.kind            = KIND_STORED;
              res.slot            = 3'(ch_idx);
              res.battery_percent = wdata.battery;
              res.temperature     = wdata.temperature;
              res.humidity        = wdata.humidity;
              res.up_time         = wdata.up_time;
            end else begin
              res.kind = KIND_FULL;
            end
          end
          OP_FRAME22: begin
            if (rm_found) begin
              res.kind = KIND_DUP;
              res.slot = 3'(rm_idx);
            end else begin
              res.kind             = KIND_MINMAX;
              res.high_temperature = scale_signed({cur.bytes[7], cur.bytes[6]});
              res.high_time        = {cur.bytes[11], cur.bytes[10], cur.bytes[9], cur.bytes[8]};
              res.low_temperature  = scale_signed({cur.bytes[13], cur.bytes[12]});
              res.low_time         = {cur.bytes[17], cur.bytes[16], cur.bytes[15], cur.bytes[14]};
            end
          end
          default: begin
            res.kind        = KIND_BADLEN;
            res.mac_address = '0;
          end
        endcase
      end
      S_SW_EMIT: begin
        res.kind            = KIND_ENTRY;
        res.slot            = 3'(sw_idx);
        res.mac_address     = rdata.mac;
        res.battery_percent = rdata.battery;
        res.temperature     = rdata.temperature;
        res.humidity        = rdata.humidity;
        res.up_time         = rdata.up_time;
        res_push            = sw_flag && (sw_cnt < 4'(SWEEP_MAX)) && !res_full;
      end
      S_SW_DONE: begin
        res.kind        = KIND_DONE;
        res.last_result = 1'b1;
        res_push        = !res_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if (rst) begin
      state        <= S_IDLE;
      upload_ready <= '0;
      log_ready    <= '0;
      rd_valid     <= 1'b0;
      scan_cnt     <= '0;
      rm_found     <= 1'b0;
      ch_found     <= 1'b0;
      sw_idx       <= '0;
      sw_cnt       <= '0;
      sw_log       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            scan_cnt <= '0;
            rd_valid <= 1'b0;
            rm_found <= 1'b0;
            ch_found <= 1'b0;
            sw_idx   <= '0;
            sw_cnt   <= '0;
            sw_log   <= (job.op == OP_LOG);
            case (job.op)
              OP_FRAME20, OP_FRAME22: state <= S_SCAN;
              OP_UPLOAD, OP_LOG:      state <= S_SW_RD;
              default:                state <= S_RESOLVE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_cnt < CNT_W'(SENSOR_SLOTS)) begin
            rd_valid <= 1'b1;
            rd_idx   <= scan_cnt[SLOT_W-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
          if (rd_valid) begin
            if (!rm_found && mac_hit && slot_ready) begin
              rm_found <= 1'b1;
              rm_idx   <= rd_idx;
              rm_time  <= rdata.update_time;
            end
            if (!ch_found && (mac_hit || !slot_ready)) begin
              ch_found <= 1'b1;
              ch_idx   <= rd_idx;
            end
            if (rd_idx == SLOT_W'(SENSOR_SLOTS - 1)) begin
              state <= S_RESOLVE;
            end
          end
        end
        S_RESOLVE: begin
          if (!res_full) begin
            if (ram_we) begin
              upload_ready[ch_idx] <= 1'b1;
              log_ready[ch_idx]    <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_SW_RD: begin
          state <= (sw_idx == CNT_W'(SENSOR_SLOTS)) ? S_SW_DONE : S_SW_EMIT;
        end
        S_SW_EMIT: begin
          if (res_push) begin
            if (sw_log) begin
              log_ready[sw_idx[SLOT_W-1:0]] <= 1'b0;
            end else begin
              upload_ready[sw_idx[SLOT_W-1:0]] <= 1'b0;
            end
            sw_cnt <= sw_cnt + 4'd1;
          end
          if (res_push || !(sw_flag && (sw_cnt < 4'(SWEEP_MAX)))) begin
            sw_idx <= sw_idx + 1'b1;
            state  <= S_SW_RD;
          end
        end
        S_SW_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into a full queue");
  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_RESOLVE) && ch_found && !is_dup20)
    else $error("table written outside a store");
  a_store_sets: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> upload_ready[$past(ch_idx)] && log_ready[$past(ch_idx)])
    else $error("stored slot not marked ready");
endmodule

// File: src/sensor_advert_parser_table_core.sv
// Top level of the beacon advert parser with its sensor slot table.
//
//  channel   | handshake          | payload / notes
//  ----------+--------------------+-----------------------------------------------
//  request   | push / full        | sapt_in_t: command, byte_value, last_byte, now
//  result    | pop / empty        | sapt_out_t, oldest result first
//  config    | APB psel/penable   | duplicate_window_ms at address 0, pready tied high
//
// A byte request is taken while the job queue has room. A 20 or 22 byte frame
// then passes through job pop, a scan of all SENSOR_SLOTS slots through the
// registered RAM port and resolve in the back end; a bad length goes from job pop
// to resolve; a sweep reads and emits each ready slot in turn, then a done result.
// A two-deep job queue lets further bytes arrive while the back end scans.
// Reset (rst, synchronous) empties both queues, clears the ready flags and the
// frame count and loads the 30000 ms window. full rises only when the job
// queue is full; a stalled pop holds the result on the output queue head.
module sensor_advert_parser_table_core #(
  parameter int SENSOR_SLOTS      = 8,
  parameter int FRAME_STORE_BYTES = 22
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sapt_pkg::sapt_in_t  request,
  output logic                empty,
  input  logic                pop,
  output sapt_pkg::sapt_out_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sapt_pkg::*;

  localparam logic ADDR_WINDOW = 1'b0;

  logic        [31:0] window;
  sapt_job_t          job_in;
  sapt_job_t          job_out;
  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_empty;
  sapt_out_t          res;
  logic               res_push;
  logic               res_full;

  // config register, written on the APB access phase
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WINDOW) ? window : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= 32'd30000;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW)) begin
      window <= pwdata;
    end
  end

  // front: byte collection and classification
  sapt_front #(
    .FRAME_STORE_BYTES (FRAME_STORE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  // decoupling queue between front and back
  sapt_fifo #(
    .ITEM_T (sapt_job_t),
    .DEPTH  (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .din   (job_in),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_out)
  );

  // back: table search, store and sweeps
  sapt_back #(
    .SENSOR_SLOTS (SENSOR_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .window    (window),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // result queue seen by the consumer
  sapt_fifo #(
    .ITEM_T (sapt_out_t),
    .DEPTH  (4)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );
endmodule

// File: verif/sensor_advert_parser_table_core_tb.sv
// Self-checking bench for the beacon advert parser and its sensor table.
module sensor_advert_parser_table_core_tb;
  import sapt_pkg::*;

  localparam int NSLOT = 8;
  localparam int LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  sapt_in_t    request = '0;
  logic        empty;
  logic        pop = 1'b0;
  sapt_out_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sensor_advert_parser_table_core i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: a mirror of the sensor table
  logic [7:0]  rx_bytes [22];
  int          rx_len;
  logic [47:0] tbl_mac [NSLOT];
  logic [6:0]  tbl_batt [NSLOT];
  logic [15:0] tbl_temp [NSLOT];
  logic [15:0] tbl_hum [NSLOT];
  logic [31:0] tbl_up [NSLOT];
  logic        up_rdy [NSLOT];
  logic        log_rdy [NSLOT];
  logic [31:0] tbl_stamp [NSLOT];
  logic [31:0] dup_window;

  sapt_in_t  pending_requests [$];
  sapt_out_t expected_results [$];
  int        errors = 0;
  int        results_seen = 0;
  int        requests_sent = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;     // last part: no idling
  bit        hold_pop = 1'b0;  // long receiver stall

  function automatic logic [6:0] mv_to_pct(input logic [15:0] mv);
    int v;
    v = mv;
    if (v >= 3000) return 7'd100;
    if (v >= 2600) return 7'(60 + (v - 2600) / 10);
    if (v >= 2500) return 7'(40 + (v - 2500) / 5);
    if (v >= 2400) return 7'(20 + (v - 2400) / 5);
    return 7'd0;
  endfunction

  function automatic logic [15:0] tenths_signed(input logic [15:0] r);
    int v;
    v = $signed(r);
    v = (v * 10) / 16;
    return 16'(v);
  endfunction

  function automatic logic [15:0] le16_at(input int at);
    return {rx_bytes[at + 1], rx_bytes[at]};
  endfunction

  function automatic logic [31:0] le32_at(input int at);
    return {le16_at(at + 2), le16_at(at)};
  endfunction

  function automatic sapt_out_t plain_result(input logic [2:0] k, input int s);
    sapt_out_t r;
    r = '0;
    r.kind = k;
    r.slot = 3'(s);
    return r;
  endfunction

  task automatic run_sweep(input bit is_log);
    sapt_out_t r;
    for (int i = 0; i < NSLOT; i++) begin
      if (is_log ? log_rdy[i] : up_rdy[i]) begin
        r = plain_result(KIND_ENTRY, i);
        r.mac_address = tbl_mac[i];
        r.battery_percent = tbl_batt[i];
        r.temperature = tbl_temp[i];
        r.humidity = tbl_hum[i];
        r.up_time = tbl_up[i];
        expected_results.push_back(r);
        if (is_log) log_rdy[i] = 1'b0;
        else up_rdy[i] = 1'b0;
      end
    end
    r = plain_result(KIND_DONE, 0);
    r.last_result = 1'b1;
    expected_results.push_back(r);
  endtask

  task automatic decode_frame(input logic [31:0] now);
    sapt_out_t   r;
    logic [47:0] mac;
    int          hit;
    int          pick;
    mac = '0;
    hit = -1;
    pick = -1;
    if (rx_len != 20 && rx_len != 22) begin
      r = plain_result(KIND_BADLEN, 0);
      r.last_result = 1'b1;
      expected_results.push_back(r);
      return;
    end
    for (int i = 4; i < 10; i++) mac = {mac[39:0], rx_bytes[i]};
    for (int i = NSLOT - 1; i >= 0; i--)
      if (tbl_mac[i] == mac && up_rdy[i]) hit = i;
    if (rx_len == 20) begin
      if (hit >= 0 && now < 32'(tbl_stamp[hit] + dup_window)) begin
        r = plain_result(KIND_DUP, hit);
      end else begin
        for (int i = NSLOT - 1; i >= 0; i--)
          if (tbl_mac[i] == mac || !up_rdy[i]) pick = i;
        if (pick < 0) begin
          r = plain_result(KIND_FULL, 0);
        end else begin
          tbl_mac[pick] = mac;
          tbl_batt[pick] = mv_to_pct(le16_at(10));
          tbl_temp[pick] = tenths_signed(le16_at(12));
          tbl_hum[pick] = 16'((32'(le16_at(14)) * 10) / 16);
          tbl_up[pick] = le32_at(16);
          up_rdy[pick] = 1'b1;
          log_rdy[pick] = 1'b1;
          tbl_stamp[pick] = now;
          r = plain_result(KIND_STORED, pick);
          r.battery_percent = tbl_batt[pick];
          r.temperature = tbl_temp[pick];
          r.humidity = tbl_hum[pick];
          r.up_time = tbl_up[pick];
        end
      end
    end else if (hit >= 0) begin
      r = plain_result(KIND_DUP, hit);
    end else begin
      r = plain_result(KIND_MINMAX, 0);
      r.high_temperature = tenths_signed(le16_at(10));
      r.high_time = le32_at(12);
      r.low_temperature = tenths_signed(le16_at(16));
      r.low_time = le32_at(18);
    end
    r.mac_address = mac;
    r.last_result = 1'b1;
    expected_results.push_back(r);
  endtask

  // Advance the mirror by one accepted request
  task automatic predict_request(input sapt_in_t q);
    case (q.command)
      CMD_UPLOAD: run_sweep(1'b0);
      CMD_LOG:    run_sweep(1'b1);
      CMD_BYTE: begin
        if (rx_len < 22) rx_bytes[rx_len] = q.byte_value;
        if (rx_len < 31) rx_len++;
        if (q.last_byte) begin
          decode_frame(q.now_ms);
          rx_len = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Driver: offers the head of the pending queue, with random idle bursts
  int idle_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_request(request);
        requests_sent++;
        void'(pending_requests.pop_front());
      end
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        push <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(0, 3);
          push <= 1'b0;
        end else begin
          push <= 1'b1;
          request <= pending_requests[0];
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compares each popped result with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    sapt_out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got %p", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.kind != result.kind || want.slot != result.slot ||
              want.mac_address != result.mac_address ||
              want.battery_percent != result.battery_percent ||
              want.temperature != result.temperature ||
              want.humidity != result.humidity || want.up_time != result.up_time ||
              want.high_temperature != result.high_temperature ||
              want.high_time != result.high_time ||
              want.low_temperature != result.low_temperature ||
              want.low_time != result.low_time ||
              want.last_result != result.last_result) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, result);
            errors++;
          end
        end
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sensor_advert_parser_table_core_tb: errors");
      $finish;
    end
  end

  // Long receiver hold-off so the request side fills and stalls
  initial begin
    wait (requests_sent > 60);
    hold_pop = 1'b1;
    repeat (300) @(posedge clk);
    hold_pop = 1'b0;
  end

  task automatic queue_req(input logic [1:0] c, input logic [7:0] b,
                           input bit l, input logic [31:0] t);
    sapt_in_t q;
    q.command = c;
    q.byte_value = b;
    q.last_byte = l;
    q.now_ms = t;
    pending_requests.push_back(q);
  endtask

  // Queue one frame of len bytes; fields overlay a random body
  task automatic queue_frame(input int len, input logic [47:0] mac,
                             input logic [15:0] w10, input logic [15:0] w12,
                             input logic [15:0] w14, input logic [31:0] w16,
                             input logic [31:0] now);
    logic [7:0] b [48];
    for (int i = 0; i < 48; i++) b[i] = 8'($urandom);
    for (int i = 0; i < 6; i++) b[4 + i] = mac[47 - 8 * i -: 8];
    {b[11], b[10]} = w10;
    {b[13], b[12]} = w12;
    {b[15], b[14]} = w14;
    {b[19], b[18], b[17], b[16]} = w16;
    for (int i = 0; i < len; i++)
      queue_req(CMD_BYTE, b[i], i == len - 1, now);
  endtask

  task automatic drain_all();
    wait (pending_requests.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  // Window write through the APB port
  task automatic set_window(input logic [31:0] w);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dup_window = w;
  endtask

  logic [47:0] macs [12];
  int          len_pick;
  logic [31:0] clock_ms;
  logic [31:0] windows [4] = '{32'd0, 32'hFFFF_FFFF, 32'd30000, 32'd5};

  initial begin
    rx_len = 0;
    dup_window = 32'd30000;
    clock_ms = 32'd1000;
    foreach (tbl_mac[i]) begin
      tbl_mac[i] = '0; up_rdy[i] = 0; log_rdy[i] = 0; tbl_stamp[i] = '0;
      tbl_batt[i] = '0; tbl_temp[i] = '0; tbl_hum[i] = '0; tbl_up[i] = '0;
    end
    foreach (macs[i]) macs[i] = {$urandom, 16'($urandom)};
    macs[0] = '0;
    macs[1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: battery bands, temperature extremes, duplicate, min/max,
    // bad lengths (short, long), unused command, sweeps
    queue_frame(20, macs[0], 16'd3000, 16'h8000, 16'hFFFF, '1, 32'd100);
    queue_frame(20, macs[1], 16'd2650, 16'h7FFF, 16'h0000, '0, 32'd200);
    queue_frame(20, macs[1], 16'd2400, 16'hFFF1, 16'd1, 32'd5, 32'd300);
    queue_frame(20, macs[2], 16'd2555, 16'd1, 16'd16, 32'd7, 32'hFFFF_FFFF);
    queue_frame(20, macs[3], 16'd2399, 16'hFFFF, 16'd17, 32'd7, 32'd0);
    queue_frame(22, macs[1], '0, '0, '0, '0, 32'd400);
    queue_frame(22, macs[9], 16'h8000, '1, 16'h7FFF, '0, 32'd400);
    queue_frame(1, macs[9], '0, '0, '0, '0, 32'd1);
    queue_frame(40, macs[9], '0, '0, '0, '0, 32'd1);
    queue_req(2'd3, 8'hA5, 1'b1, '0);
    queue_req(CMD_UPLOAD, '0, 1'b0, '0);
    queue_req(CMD_LOG, 8'hFF, 1'b1, '1);
    queue_req(CMD_UPLOAD, '0, 1'b0, '0);
    drain_all();

    // Random phases through several window settings
    for (int ph = 0; ph < 4; ph++) begin
      set_window(windows[ph]);
      if (ph == 3) quiet = 1'b1;
      for (int n = 0; n < 2; n++) begin
        clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40);
        len_pick = $urandom_range(0, 19);
        if (len_pick < 2) begin
          queue_req(2'($urandom_range(1, 2)), 8'($urandom), 1'($urandom), $urandom);
        end else if (len_pick == 2) begin
          queue_req(2'd3, 8'($urandom), 1'($urandom), $urandom);
        end else if (len_pick == 3) begin
          queue_frame($urandom_range(1, 30), macs[$urandom_range(0, 3)],
                      '0, '0, '0, '0, clock_ms);
        end else begin
          queue_frame(len_pick < 16 ? 20 : 22, macs[$urandom_range(0, 3)],
                      16'($urandom_range(2350, 3050)), 16'($urandom), 16'($urandom),
                      $urandom, clock_ms);
        end
      end
      drain_all();
    end
    set_window(32'd30000);

    $display("Covered %0d requests and %0d results: all frame kinds, sweeps,",
             requests_sent, results_seen);
    $display("window extremes, and a long result-side stall.");
    if (errors == 0) begin
      $display("sensor_advert_parser_table_core_tb: clean");
    end else begin
      $display("sensor_advert_parser_table_core_tb: errors");
    end
    $finish;
  end

endmodule
